FILE: hdl/ptc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared constants and helpers for the pressure/temperature compensation core.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned NumCfg   = 7;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgW     = 16;

  localparam logic [CfgIdxW-1:0] CfgPromWord0   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSensBase    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOffsetBase  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSensTempco  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgOffTempco   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRefTemp     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgTempGain    = 3'd6;

  localparam int unsigned RawW    = 24;
  localparam int unsigned TempW   = 19;
  localparam int unsigned PressW  = 26;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  localparam int unsigned DtW     = 25;
  localparam int unsigned ProdW   = 42;
  localparam int unsigned SumW    = 43;
  localparam int unsigned OffW    = 36;
  localparam int unsigned SensW   = 35;
  localparam int unsigned SensLoW = 17;
  localparam int unsigned PhW     = 43;
  localparam int unsigned PlW     = 41;
  localparam int unsigned FullW   = 60;
  localparam int unsigned QW      = 39;
  localparam int unsigned RW      = 40;

  localparam int unsigned TempShift  = 23;
  localparam int unsigned OffShift   = 7;
  localparam int unsigned SensShift  = 8;
  localparam int unsigned MulShift   = 21;
  localparam int unsigned PressShift = 13;

  localparam longint TempBaseScaled = 64'sd2000 * (64'sd1 <<< TempShift);

  localparam logic [CfgW-1:0] CrcPoly     = 16'h3000;
  localparam int unsigned     CrcBytes    = 16;
  localparam int unsigned     CrcCntW     = 4;

  function automatic logic [CfgW-1:0] crc4_byte(input logic [CfgW-1:0] rem_in,
                                                input logic [7:0]      data);
    logic [CfgW-1:0] rem;
    rem = rem_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (rem[CfgW-1]) begin
        rem = (rem << 1) ^ CrcPoly;
      end else begin
        rem = rem << 1;
      end
    end
    return rem;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/pressure_temp_compensation_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pressure_temp_compensation_core
// First-order pressure/temperature compensation with CRC-4 calibration check.
// ----------------------------------------------------------------------------
// Input stream carries one raw pressure / temperature pair per request; the
// output stream returns compensated temperature (0.01 degC), pressure
// (0.1 mbar) and the calibration-ok flag in tuser.
// Pipeline of six register stages: dT, three coefficient products, truncating
// scale, split pressure product, product merge, final offset and shift into
// the output register. One request per cycle is sustained while the receiver
// does not stall and no CRC check runs.
// A receiver stall holds the output register; upstream stages keep filling
// empty slots; input tready drops only in a CRC run or with every stage full.
// Calibration words sit behind the APB port. Each write restarts a byte-serial
// CRC-4 over 16 bytes, the seven words plus two zero bytes, with input tready
// low. After reset all words are 0, the CRC matches and calib_ok is 1.
// When calib_ok is 0 both result fields read as 0.
// ----------------------------------------------------------------------------
module pressure_temp_compensation_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // stream in
  input  wire logic                         s_axis_tvalid_i,
  output      logic                         s_axis_tready_o,
  // [23:0] pressure_raw, [47:24] temperature_raw
  input  wire logic [ptc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // stream out
  output      logic                         m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // [18:0] temp_centideg, [44:19] pressure_decimbar, [47:45] zero
  output      logic [ptc_pkg::OutDataW-1:0] m_axis_tdata_o,
  // [0] calib_ok
  output      logic                         m_axis_tuser_o,
  // APB config
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ptc_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output      logic [31:0]                  prdata,
  output      logic                         pready
);

  localparam int unsigned NumStages = 6;

  // ---------------- configuration ----------------
  logic [ptc_pkg::CfgW-1:0] prom0_q, c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic [ptc_pkg::CfgIdxW-1:0] cfg_idx;
  logic                        cfg_wr;
  logic [ptc_pkg::CfgW-1:0]    cfg_rd;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ptc_pkg::CfgAddrW-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prom0_q <= '0;
      c1_q    <= '0;
      c2_q    <= '0;
      c3_q    <= '0;
      c4_q    <= '0;
      c5_q    <= '0;
      c6_q    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ptc_pkg::CfgPromWord0:  prom0_q <= pwdata[ptc_pkg::CfgW-1:0];
        ptc_pkg::CfgSensBase:   c1_q    <= pwdata[ptc_pkg::CfgW-1:0];
        ptc_pkg::CfgOffsetBase: c2_q    <= pwdata[ptc_pkg::CfgW-1:0];
        ptc_pkg::CfgSensTempco: c3_q    <= pwdata[ptc_pkg::CfgW-1:0];
        ptc_pkg::CfgOffTempco:  c4_q    <= pwdata[ptc_pkg::CfgW-1:0];
        ptc_pkg::CfgRefTemp:    c5_q    <= pwdata[ptc_pkg::CfgW-1:0];
        ptc_pkg::CfgTempGain:   c6_q    <= pwdata[ptc_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ptc_pkg::CfgPromWord0:  cfg_rd = prom0_q;
      ptc_pkg::CfgSensBase:   cfg_rd = c1_q;
      ptc_pkg::CfgOffsetBase: cfg_rd = c2_q;
      ptc_pkg::CfgSensTempco: cfg_rd = c3_q;
      ptc_pkg::CfgOffTempco:  cfg_rd = c4_q;
      ptc_pkg::CfgRefTemp:    cfg_rd = c5_q;
      ptc_pkg::CfgTempGain:   cfg_rd = c6_q;
      default:                cfg_rd = '0;
    endcase
  end

  assign prdata = {16'h0000, cfg_rd};

  // ---------------- byte-serial CRC-4 ----------------
  logic                        crc_busy_q;
  logic [ptc_pkg::CrcCntW-1:0] crc_cnt_q;
  logic [ptc_pkg::CfgW-1:0]    crc_rem_q, crc_rem_d;
  logic                        calib_ok_q;
  logic [ptc_pkg::CfgW-1:0]    crc_word;
  logic [7:0]                  crc_byte;

  always_comb begin
    case (crc_cnt_q[ptc_pkg::CrcCntW-1:1])
      ptc_pkg::CfgPromWord0:  crc_word = {4'h0, prom0_q[11:0]};
      ptc_pkg::CfgSensBase:   crc_word = c1_q;
      ptc_pkg::CfgOffsetBase: crc_word = c2_q;
      ptc_pkg::CfgSensTempco: crc_word = c3_q;
      ptc_pkg::CfgOffTempco:  crc_word = c4_q;
      ptc_pkg::CfgRefTemp:    crc_word = c5_q;
      ptc_pkg::CfgTempGain:   crc_word = c6_q;
      default:                crc_word = '0;
    endcase
    crc_byte  = crc_cnt_q[0] ? crc_word[7:0] : crc_word[15:8];
    crc_rem_d = ptc_pkg::crc4_byte(crc_rem_q, crc_byte);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_busy_q <= 1'b0;
      crc_cnt_q  <= '0;
      crc_rem_q  <= '0;
      calib_ok_q <= 1'b1;
    end else if (cfg_wr) begin
      crc_busy_q <= 1'b1;
      crc_cnt_q  <= '0;
      crc_rem_q  <= '0;
    end else if (crc_busy_q) begin
      crc_rem_q <= crc_rem_d;
      crc_cnt_q <= crc_cnt_q + 1'b1;
      if (crc_cnt_q == ptc_pkg::CrcCntW'(ptc_pkg::CrcBytes - 1)) begin
        crc_busy_q <= 1'b0;
        calib_ok_q <= (crc_rem_d[15:12] == prom0_q[15:12]);
      end
    end
  end

  // ---------------- pipeline control ----------------
  logic [NumStages:1] vld_q;
  logic [NumStages:1] en;
  logic               in_fire;

  always_comb begin
    en[NumStages] = ~vld_q[NumStages] | m_axis_tready_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  assign s_axis_tready_o = en[1] & ~crc_busy_q;
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) begin
        vld_q[1] <= in_fire;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------- stage 1: dT ----------------
  logic [ptc_pkg::RawW-1:0]       s1_d1_q;
  logic signed [ptc_pkg::DtW-1:0] s1_dt_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_d1_q <= s_axis_tdata_i[ptc_pkg::RawW-1:0];
      s1_dt_q <= $signed({1'b0, s_axis_tdata_i[2*ptc_pkg::RawW-1:ptc_pkg::RawW]})
               - $signed({1'b0, c5_q, 8'h00});
    end
  end

  // ---------------- stage 2: coefficient products ----------------
  logic [ptc_pkg::RawW-1:0]         s2_d1_q;
  logic signed [ptc_pkg::ProdW-1:0] s2_mt_q, s2_mo_q, s2_ms_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_d1_q <= s1_d1_q;
      s2_mt_q <= s1_dt_q * $signed({1'b0, c6_q});
      s2_mo_q <= s1_dt_q * $signed({1'b0, c4_q});
      s2_ms_q <= s1_dt_q * $signed({1'b0, c3_q});
    end
  end

  // ---------------- stage 3: offsets and truncating shifts ----------------
  logic signed [ptc_pkg::SumW-1:0] t_sum, o_sum, s_sum, t_adj, o_adj, s_adj;

  always_comb begin
    t_sum = $signed(ptc_pkg::SumW'(ptc_pkg::TempBaseScaled))
          + ptc_pkg::SumW'(s2_mt_q);
    o_sum = $signed({4'h0, c2_q, 23'h0}) + ptc_pkg::SumW'(s2_mo_q);
    s_sum = $signed({4'h0, c1_q, 23'h0}) + ptc_pkg::SumW'(s2_ms_q);
    t_adj = t_sum + (t_sum[ptc_pkg::SumW-1]
          ? $signed(ptc_pkg::SumW'((64'd1 << ptc_pkg::TempShift) - 1)) : '0);
    o_adj = o_sum + (o_sum[ptc_pkg::SumW-1]
          ? $signed(ptc_pkg::SumW'((64'd1 << ptc_pkg::OffShift) - 1)) : '0);
    s_adj = s_sum + (s_sum[ptc_pkg::SumW-1]
          ? $signed(ptc_pkg::SumW'((64'd1 << ptc_pkg::SensShift) - 1)) : '0);
  end

  logic [ptc_pkg::RawW-1:0]          s3_d1_q;
  logic [ptc_pkg::TempW-1:0]         s3_temp_q;
  logic signed [ptc_pkg::OffW-1:0]   s3_off_q;
  logic signed [ptc_pkg::SensW-1:0]  s3_sens_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_d1_q   <= s2_d1_q;
      s3_temp_q <= t_adj[ptc_pkg::TempShift+ptc_pkg::TempW-1:ptc_pkg::TempShift];
      s3_off_q  <= o_adj[ptc_pkg::SumW-1:ptc_pkg::OffShift];
      s3_sens_q <= s_adj[ptc_pkg::SumW-1:ptc_pkg::SensShift];
    end
  end

  // ---------------- stage 4: split pressure product ----------------
  logic [ptc_pkg::TempW-1:0]        s4_temp_q;
  logic signed [ptc_pkg::OffW-1:0]  s4_off_q;
  logic signed [ptc_pkg::PhW-1:0]   s4_ph_q;
  logic [ptc_pkg::PlW-1:0]          s4_pl_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_temp_q <= s3_temp_q;
      s4_off_q  <= s3_off_q;
      s4_ph_q   <= $signed({1'b0, s3_d1_q})
                 * $signed(s3_sens_q[ptc_pkg::SensW-1:ptc_pkg::SensLoW]);
      s4_pl_q   <= s3_d1_q * s3_sens_q[ptc_pkg::SensLoW-1:0];
    end
  end

  // ---------------- stage 5: merge product, floor shift ----------------
  logic signed [ptc_pkg::FullW-1:0] full_prod;

  assign full_prod = ($signed(ptc_pkg::FullW'(s4_ph_q)) <<< ptc_pkg::SensLoW)
                   + $signed({{(ptc_pkg::FullW-ptc_pkg::PlW){1'b0}}, s4_pl_q});

  logic [ptc_pkg::TempW-1:0]        s5_temp_q;
  logic signed [ptc_pkg::OffW-1:0]  s5_off_q;
  logic signed [ptc_pkg::QW-1:0]    s5_q_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_temp_q <= s4_temp_q;
      s5_off_q  <= s4_off_q;
      s5_q_q    <= full_prod[ptc_pkg::FullW-1:ptc_pkg::MulShift];
    end
  end

  // ---------------- stage 6: output register ----------------
  logic signed [ptc_pkg::RW-1:0]  p_diff;
  logic [ptc_pkg::TempW-1:0]      out_temp_q;
  logic [ptc_pkg::PressW-1:0]     out_press_q;
  logic                           out_ok_q;

  assign p_diff = ptc_pkg::RW'(s5_q_q) - ptc_pkg::RW'(s5_off_q);

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      out_ok_q    <= calib_ok_q;
      out_temp_q  <= calib_ok_q ? s5_temp_q : '0;
      out_press_q <= calib_ok_q
                   ? p_diff[ptc_pkg::PressShift+ptc_pkg::PressW-1:ptc_pkg::PressShift]
                   : '0;
    end
  end

  assign m_axis_tvalid_o = vld_q[NumStages];
  assign m_axis_tuser_o  = out_ok_q;
  assign m_axis_tdata_o  = {{(ptc_pkg::OutDataW-ptc_pkg::TempW-ptc_pkg::PressW){1'b0}},
                            out_press_q, out_temp_q};

  // ---------------- assertions ----------------
  a_no_accept_in_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_busy_q |-> !s_axis_tready_o)
    else $error("input taken while CRC busy");

  a_crc_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> crc_busy_q && (crc_cnt_q == '0))
    else $error("CRC not restarted after config write");

  a_bad_calib_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("nonzero result with failed calibration");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken into a full stalled pipeline");

endmodule
`default_nettype wire
